// File: hw/rtl/gf_cubic_extension_alu_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GF(131^3) arithmetic unit
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef GF_CUBIC_EXTENSION_ALU_ASSERT_SVH
`define GF_CUBIC_EXTENSION_ALU_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GFCE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfce: same-cycle implication failed");
// Next-cycle implication.
`define GFCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gfce: next-cycle implication failed");
`else
`define GFCE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GFCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/gfce_pkg.sv
// ----------------------------------------------------------------------------
// gfce_pkg
// Shared types, constants and helpers of the GF(131^3) arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfce_pkg;

  localparam int unsigned COEF_W      = 8;
  localparam int unsigned EXP_BITS    = 22;
  localparam int unsigned P_MOD       = 131;
  localparam int unsigned FIELD_ORDER = P_MOD * P_MOD * P_MOD;
  localparam int unsigned CONV_W      = 2 * COEF_W;
  // Holds any value below five times the modulus.
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned NORM_STEPS  = 6;
  localparam int unsigned STEP_W      = 3;

  typedef logic [COEF_W-1:0]      coef_t;
  typedef logic [2:0][COEF_W-1:0] elem_t;

  localparam coef_t P_COEF = COEF_W'(P_MOD);
  localparam elem_t ELEM_ZERO = '0;
  localparam elem_t ELEM_ONE  = {COEF_W'(0), COEF_W'(0), COEF_W'(1)};
  // Raising to q-2 gives the inverse.
  localparam logic [EXP_BITS-1:0] INV_EXP = EXP_BITS'(FIELD_ORDER - 2);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_POW  = 3'd3;
  localparam logic [2:0] OP_INV  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  typedef enum logic [2:0] {
    MK_ACC_BASE,
    MK_BASE_BASE,
    MK_BASE_OPB,
    MK_MINOR,
    MK_TERM
  } mul_kind_t;

  typedef enum logic [2:0] {
    DEST_ACC,
    DEST_BASE,
    DEST_TMP,
    DEST_NADD,
    DEST_NSUB
  } dest_t;

  typedef struct packed {
    logic              load;
    logic              alu;
    logic              sub;
    logic              issue;
    mul_kind_t         kind;
    dest_t             dest;
    logic [STEP_W-1:0] step;
    logic              exp_shift;
    logic              publish;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic exp_zero;
    logic exp_lsb;
  } status_t;

  typedef struct packed {
    logic  issue;
    dest_t dest;
    elem_t x;
    elem_t y;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  valid;
    dest_t dest;
    elem_t value;
  } mul_rsp_t;

  // Reduces a value below five times the modulus.
  function automatic coef_t mod_small(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    if (x >= SUM_W'(4 * P_MOD)) begin
      r = x - SUM_W'(4 * P_MOD);
    end else if (x >= SUM_W'(3 * P_MOD)) begin
      r = x - SUM_W'(3 * P_MOD);
    end else if (x >= SUM_W'(2 * P_MOD)) begin
      r = x - SUM_W'(2 * P_MOD);
    end else if (x >= SUM_W'(P_MOD)) begin
      r = x - SUM_W'(P_MOD);
    end else begin
      r = x;
    end
    return COEF_W'(r);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gfce_mul.sv
// ----------------------------------------------------------------------------
// gfce_mul
// Pipelined GF(131^3) multiplier (registered convolution, then registered reduction), one product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfce_mul import gfce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / P_MOD;
  localparam int unsigned RPROD_W     = CONV_W + RECIP_SHIFT;

  logic [4:0][CONV_W-1:0] conv, conv_next;
  logic [4:0][COEF_W-1:0] red_s;
  logic                   v1, v2;
  dest_t                  dest1, dest2;
  logic [SUM_W-1:0]       n3, n4, t0, t1, t2;

  // Remainder by reciprocal multiplication; the quotient estimate is at most
  // one short, so a single subtraction corrects it.
  function automatic coef_t mod_conv(input logic [CONV_W-1:0] x);
    logic [RPROD_W-1:0] prod;
    logic [CONV_W-1:0]  q;
    logic [CONV_W-1:0]  r;
    prod = RPROD_W'(x) * RPROD_W'(RECIP);
    q    = CONV_W'(prod >> RECIP_SHIFT);
    r    = x - CONV_W'(q * CONV_W'(P_MOD));
    if (r >= CONV_W'(P_MOD)) begin
      r = r - CONV_W'(P_MOD);
    end
    return COEF_W'(r);
  endfunction

  always_comb begin
    conv_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        conv_next[i+j] = conv_next[i+j] + CONV_W'(req.x[i]) * CONV_W'(req.y[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.issue;
      v2 <= v1;
    end
    conv  <= conv_next;
    dest1 <= req.dest;
    dest2 <= dest1;
    for (int k = 0; k < 5; k++) begin
      red_s[k] <= mod_conv(conv[k]);
    end
  end

  // Fold t^3 = -t - 3 and t^4 = -t^2 - 3t back into the basis.
  always_comb begin
    n3 = SUM_W'(P_MOD) - SUM_W'(red_s[3]);
    n4 = SUM_W'(P_MOD) - SUM_W'(red_s[4]);
    t0 = SUM_W'(red_s[0]) + SUM_W'(3) * n3;
    t1 = SUM_W'(red_s[1]) + SUM_W'(3) * n4 + n3;
    t2 = SUM_W'(red_s[2]) + n4;
  end

  assign rsp.busy  = v1 | v2;
  assign rsp.valid = v2;
  assign rsp.dest  = dest2;
  assign rsp.value = {mod_small(t2), mod_small(t1), mod_small(t0)};

endmodule

`default_nettype wire

// File: hw/rtl/gfce_datapath.sv
// ----------------------------------------------------------------------------
// gfce_datapath
// Operand, accumulator and exponent registers around the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfce_datapath import gfce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [2:0]          operation,
  input  coef_t               a_c0,
  input  coef_t               a_c1,
  input  coef_t               a_c2,
  input  coef_t               b_c0,
  input  coef_t               b_c1,
  input  coef_t               b_c2,
  input  logic [EXP_BITS-1:0] exponent,
  output status_t             status,
  output coef_t               r_c0,
  output coef_t               r_c1,
  output coef_t               r_c2,
  output logic                error
);

  elem_t               a_red, b_red, a_t, a_tt, alu_res;
  elem_t               acc, base, opb, m2, r_out;
  coef_t               tmp;
  coef_t               sx, sy, sa;
  logic [EXP_BITS-1:0] expr;
  logic                err, err_out;
  mul_req_t            req;
  mul_rsp_t            rsp;

  function automatic elem_t mul_by_t(input elem_t e);
    elem_t r;
    r[0] = mod_small(SUM_W'(3) * (SUM_W'(P_MOD) - SUM_W'(e[2])));
    r[1] = mod_small(SUM_W'(e[0]) + SUM_W'(P_MOD) - SUM_W'(e[2]));
    r[2] = e[1];
    return r;
  endfunction

  always_comb begin
    a_red = {mod_small(SUM_W'(a_c2)), mod_small(SUM_W'(a_c1)), mod_small(SUM_W'(a_c0))};
    b_red = {mod_small(SUM_W'(b_c2)), mod_small(SUM_W'(b_c1)), mod_small(SUM_W'(b_c0))};
    // Columns of the multiplication matrix: a, a*t, a*t^2.
    a_t   = mul_by_t(a_red);
    a_tt  = mul_by_t(a_t);
    for (int i = 0; i < 3; i++) begin
      if (cmd.sub) begin
        alu_res[i] = mod_small(SUM_W'(base[i]) + SUM_W'(P_MOD) - SUM_W'(opb[i]));
      end else begin
        alu_res[i] = mod_small(SUM_W'(base[i]) + SUM_W'(opb[i]));
      end
    end
  end

  // Determinant terms: the first three are added, the last three subtracted.
  always_comb begin
    case (cmd.step)
      3'd0: begin sx = opb[1]; sy = m2[2]; sa = base[0]; end
      3'd1: begin sx = opb[2]; sy = m2[0]; sa = base[1]; end
      3'd2: begin sx = opb[0]; sy = m2[1]; sa = base[2]; end
      3'd3: begin sx = opb[2]; sy = m2[1]; sa = base[0]; end
      3'd4: begin sx = opb[0]; sy = m2[2]; sa = base[1]; end
      3'd5: begin sx = opb[1]; sy = m2[0]; sa = base[2]; end
      default: begin sx = '0; sy = '0; sa = '0; end
    endcase
  end

  always_comb begin
    req.issue = cmd.issue;
    req.dest  = cmd.dest;
    case (cmd.kind)
      MK_ACC_BASE:  begin req.x = acc;  req.y = base; end
      MK_BASE_BASE: begin req.x = base; req.y = base; end
      MK_BASE_OPB:  begin req.x = base; req.y = opb;  end
      MK_MINOR: begin
        req.x = {COEF_W'(0), COEF_W'(0), sx};
        req.y = {COEF_W'(0), COEF_W'(0), sy};
      end
      MK_TERM: begin
        req.x = {COEF_W'(0), COEF_W'(0), tmp};
        req.y = {COEF_W'(0), COEF_W'(0), sa};
      end
      default: begin req.x = ELEM_ZERO; req.y = ELEM_ZERO; end
    endcase
  end

  gfce_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= a_red;
      opb  <= (operation == OP_NORM) ? a_t : b_red;
      m2   <= a_tt;
      acc  <= (operation inside {OP_POW, OP_INV}) ? ELEM_ONE : ELEM_ZERO;
      expr <= (operation == OP_INV) ? INV_EXP : exponent;
      err  <= (operation == OP_INV) && (a_red == ELEM_ZERO);
    end else begin
      if (cmd.alu) begin
        acc <= alu_res;
      end
      if (cmd.exp_shift) begin
        expr <= expr >> 1;
      end
      if (rsp.valid) begin
        case (rsp.dest)
          DEST_ACC:  acc  <= rsp.value;
          DEST_BASE: base <= rsp.value;
          DEST_TMP:  tmp  <= rsp.value[0];
          DEST_NADD: acc[0] <= mod_small(SUM_W'(acc[0]) + SUM_W'(rsp.value[0]));
          DEST_NSUB: acc[0] <= mod_small(SUM_W'(acc[0]) + SUM_W'(P_MOD)
                                         - SUM_W'(rsp.value[0]));
          default: ;
        endcase
      end
    end
    if (cmd.publish) begin
      r_out   <= acc;
      err_out <= err;
    end
  end

  assign status.mul_busy = rsp.busy;
  assign status.exp_zero = (expr == '0);
  assign status.exp_lsb  = expr[0];

  assign r_c0  = r_out[0];
  assign r_c1  = r_out[1];
  assign r_c2  = r_out[2];
  assign error = err_out;

endmodule

`default_nettype wire

// File: hw/rtl/gfce_ctrl.sv
// ----------------------------------------------------------------------------
// gfce_ctrl
// Sequencer for the GF(131^3) unit: handshakes and multiplier schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfce_ctrl import gfce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] operation,
  input  status_t    status,
  input  logic       out_stall,
  output logic       in_stall,
  output logic       out_valid,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALU,
    S_MUL,
    S_POW_MUL,
    S_POW_SQR,
    S_NRM_MINOR,
    S_NRM_TERM,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t            state, ret_state;
  logic [2:0]        op_reg;
  logic [STEP_W-1:0] step;

  assign in_stall = rst | (state != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.kind  = MK_ACC_BASE;
    cmd.dest  = DEST_ACC;
    cmd.step  = step;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_ALU: begin
        cmd.alu = 1'b1;
        cmd.sub = (op_reg == OP_SUB);
      end
      S_MUL: begin
        cmd.issue = 1'b1;
        cmd.kind  = MK_BASE_OPB;
      end
      S_POW_MUL: cmd.issue = !status.exp_zero && status.exp_lsb;
      S_POW_SQR: begin
        cmd.issue     = 1'b1;
        cmd.kind      = MK_BASE_BASE;
        cmd.dest      = DEST_BASE;
        cmd.exp_shift = 1'b1;
      end
      S_NRM_MINOR: begin
        cmd.issue = 1'b1;
        cmd.kind  = MK_MINOR;
        cmd.dest  = DEST_TMP;
      end
      S_NRM_TERM: begin
        cmd.issue = 1'b1;
        cmd.kind  = MK_TERM;
        cmd.dest  = (step < STEP_W'(NORM_STEPS / 2)) ? DEST_NADD : DEST_NSUB;
      end
      S_FINISH: cmd.publish = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      op_reg    <= OP_ADD;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_reg <= operation;
            step   <= '0;
            case (operation)
              OP_ADD, OP_SUB: state <= S_ALU;
              OP_MUL:         state <= S_MUL;
              OP_POW, OP_INV: state <= S_POW_MUL;
              OP_NORM:        state <= S_NRM_MINOR;
              default:        state <= S_FINISH;
            endcase
          end
        end
        S_ALU: state <= S_FINISH;
        S_MUL: begin
          state     <= S_WAIT;
          ret_state <= S_FINISH;
        end
        S_POW_MUL: state <= status.exp_zero ? S_FINISH : S_POW_SQR;
        S_POW_SQR: begin
          state     <= S_WAIT;
          ret_state <= S_POW_MUL;
        end
        S_NRM_MINOR: begin
          state     <= S_WAIT;
          ret_state <= S_NRM_TERM;
        end
        S_NRM_TERM: begin
          state     <= S_WAIT;
          step      <= step + STEP_W'(1);
          ret_state <= (step == STEP_W'(NORM_STEPS - 1)) ? S_FINISH : S_NRM_MINOR;
        end
        S_WAIT: begin
          if (!status.mul_busy) begin
            state <= ret_state;
          end
        end
        S_FINISH: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gf_cubic_extension_alu.sv
// ----------------------------------------------------------------------------
// gf_cubic_extension_alu
// Add, subtract, multiply, power, inverse and norm in GF(131^3).
// ----------------------------------------------------------------------------
// The unit takes one transaction at a time and returns one result for each.
// Add and subtract use the adder alone; multiply issues one product; norm
// issues two dependent products for each of six determinant terms; power
// issues a squaring for each exponent bit up to the highest set bit and a
// product for each set bit; inverse is a power with 22 exponent bits. In
// the shared field multiplier, each dependent product waits for the
// previous result to be written back. A finished result sits in the
// output register, so a new transaction is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

`include "gf_cubic_extension_alu_assert.svh"

module gf_cubic_extension_alu import gfce_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          operation,
  input  logic [7:0]          a_c0,
  input  logic [7:0]          a_c1,
  input  logic [7:0]          a_c2,
  input  logic [7:0]          b_c0,
  input  logic [7:0]          b_c1,
  input  logic [7:0]          b_c2,
  input  logic [EXP_BITS-1:0] exponent,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          r_c0,
  output logic [7:0]          r_c1,
  output logic [7:0]          r_c2,
  output logic                error
);

  cmd_t    cmd;
  status_t status;

  gfce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .status    (status),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  gfce_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .a_c0      (a_c0),
    .a_c1      (a_c1),
    .a_c2      (a_c2),
    .b_c0      (b_c0),
    .b_c1      (b_c1),
    .b_c2      (b_c2),
    .exponent  (exponent),
    .status    (status),
    .r_c0      (r_c0),
    .r_c1      (r_c1),
    .r_c2      (r_c2),
    .error     (error)
  );

  `GFCE_ASSERT_IMPLY(a_result_reduced, clk, rst, out_valid,
                     (r_c0 < P_COEF) && (r_c1 < P_COEF) && (r_c2 < P_COEF))
  `GFCE_ASSERT_IMPLY(a_error_zero, clk, rst, out_valid && error,
                     (r_c0 == '0) && (r_c1 == '0) && (r_c2 == '0))
  `GFCE_ASSERT_IMPLY(a_load_idle_mul, clk, rst, cmd.load, !status.mul_busy)
  `GFCE_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
